// ===== rtl/core/spq_pkg.sv =====
// shared constants for the sorted open-list priority queue
// used by the top level and its port checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int NODE_COUNT_DEF = 256;

  localparam int COST_W   = 32;
  localparam int NODE_W   = 8;
  localparam int LEFT_W   = 9;
  localparam int S_DATA_W = 40;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 56;
  localparam int M_USER_W = 1;

  // request modes carried on s_tuser
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_POP   = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_priority_queue_decrease_key.sv =====
// sorted open-list priority queue with decrease-key (add or reposition) and pop-min
// depends on spq_pkg; queue and cost tables are memories with one read and one write port in this module
`timescale 1ns / 1ps
`default_nettype none

//  channel  | dir | tdata (low bit up)                          | tuser
//  ---------+-----+---------------------------------------------+-------------------
//  s_*      | in  | node_index[7:0], path_cost[39:8]            | mode[1:0]
//  m_*      | out | popped_node[7:0], popped_cost[39:8],        | queue_empty[0]
//           |     | entries_left[48:40], zero[55:49]            |
//
//  clear, unused mode and empty pop go straight to the result; pop reads the node, then its cost
//  add of a closed node: cost write, a binary search, then entries moved up and the insert; a
//  search takes at most ceil(log2(n+1)) steps, n = entries queued
//  add of an open node first does an old cost read, a second search, a scan for the node and entries moved down
//  reset and clear drop all open flags at once; no table sweep is needed
//  s_tready is high only when idle; a result waiting on m_tready holds the next request in ST_FIN

module sorted_priority_queue_decrease_key #(
  parameter int NODE_COUNT = spq_pkg::NODE_COUNT_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire [spq_pkg::S_DATA_W-1:0]  s_tdata,   // node_index, path_cost
  input  wire [spq_pkg::S_USER_W-1:0]  s_tuser,   // mode
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [spq_pkg::M_DATA_W-1:0] m_tdata,   // popped_node, popped_cost, entries_left, pad
  output logic [spq_pkg::M_USER_W-1:0] m_tuser    // queue_empty
);

  localparam int IW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int CW = $clog2(NODE_COUNT + 1);
  localparam int CWD = spq_pkg::COST_W;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_OLD_COST  = 4'd1;
  localparam logic [3:0] ST_SRCH      = 4'd2;
  localparam logic [3:0] ST_SRCH_NODE = 4'd3;
  localparam logic [3:0] ST_SRCH_CMP  = 4'd4;
  localparam logic [3:0] ST_SCAN      = 4'd5;
  localparam logic [3:0] ST_SCAN_CMP  = 4'd6;
  localparam logic [3:0] ST_SHDN      = 4'd7;
  localparam logic [3:0] ST_SHDN_WR   = 4'd8;
  localparam logic [3:0] ST_NEW_COST  = 4'd9;
  localparam logic [3:0] ST_SHUP      = 4'd10;
  localparam logic [3:0] ST_SHUP_WR   = 4'd11;
  localparam logic [3:0] ST_INSERT    = 4'd12;
  localparam logic [3:0] ST_POP_NODE  = 4'd13;
  localparam logic [3:0] ST_POP_COST  = 4'd14;
  localparam logic [3:0] ST_FIN       = 4'd15;

  logic [3:0]            state;
  logic [CW-1:0]         count;
  logic [NODE_COUNT-1:0] node_open;
  logic [IW-1:0]         node;
  logic [CWD-1:0]        new_cost;
  logic [CWD-1:0]        key;
  logic [CW-1:0]         lo;
  logic [CW-1:0]         hi;
  logic [CW-1:0]         mid;
  logic [CW-1:0]         pos;
  logic [CW-1:0]         idx;
  logic                  for_old;
  logic [IW-1:0]         res_node;
  logic [CWD-1:0]        res_cost;
  logic                  res_empty;

  // memories
  logic [IW-1:0]  qmem [NODE_COUNT];
  logic [CWD-1:0] cmem [NODE_COUNT];
  logic [IW-1:0]  q_raddr;
  logic [IW-1:0]  q_rdata;
  logic           q_we;
  logic [IW-1:0]  q_waddr;
  logic [IW-1:0]  q_wdata;
  logic [IW-1:0]  c_raddr;
  logic [CWD-1:0] c_rdata;
  logic           c_we;

  logic            accept;
  logic [1:0]      in_mode;
  logic [7:0]      in_node;
  logic [CWD-1:0]  in_cost;
  logic [IW-1:0]  in_node_idx;
  logic            in_node_ok;
  logic [CW:0]     mid_sum;
  logic [CW-1:0]   mid_w;
  logic [CW-1:0]   idx_inc;
  logic [CW-1:0]   idx_dec;
  logic [CW-1:0]   count_dec;
  logic            cost_gt;

  assign s_tready    = (state == ST_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign in_mode     = s_tuser[1:0];
  assign in_node     = s_tdata[7:0];
  assign in_cost     = s_tdata[39:8];
  assign in_node_idx = IW'(in_node);
  assign in_node_ok  = (32'(in_node) < 32'(NODE_COUNT));

  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid_w     = mid_sum[CW:1];
  assign idx_inc   = idx + CW'(1);
  assign idx_dec   = idx - CW'(1);
  assign count_dec = count - CW'(1);

  // the one cost comparator, shared by both binary searches
  assign cost_gt = (c_rdata > key);

  always_comb begin
    q_raddr = count_dec[IW-1:0];
    q_we    = 1'b0;
    q_waddr = idx[IW-1:0];
    q_wdata = q_rdata;
    c_raddr = q_rdata;
    c_we    = 1'b0;
    unique case (state)
      ST_IDLE:      c_raddr = in_node_idx;
      ST_SRCH:      q_raddr = mid_w[IW-1:0];
      ST_SCAN:      q_raddr = pos[IW-1:0];
      ST_SHDN:      q_raddr = idx_inc[IW-1:0];
      ST_SHUP:      q_raddr = idx_dec[IW-1:0];
      ST_SHDN_WR:   q_we = 1'b1;
      ST_SHUP_WR:   q_we = 1'b1;
      ST_INSERT: begin
        q_we    = 1'b1;
        q_waddr = pos[IW-1:0];
        q_wdata = node;
      end
      ST_NEW_COST:  c_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    q_rdata <= qmem[q_raddr];
    if (q_we) begin
      qmem[q_waddr] <= q_wdata;
    end
  end

  always_ff @(posedge clk) begin
    c_rdata <= cmem[c_raddr];
    if (c_we) begin
      cmem[node] <= new_cost;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      node_open <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            res_node  <= '0;
            res_cost  <= '0;
            res_empty <= 1'b0;
            node      <= in_node_idx;
            new_cost  <= in_cost;
            state     <= ST_FIN;
            case (in_mode)
              spq_pkg::MODE_CLEAR: begin
                node_open <= '0;
                count     <= '0;
              end
              spq_pkg::MODE_ADD: begin
                if (in_node_ok) begin
                  state <= node_open[in_node_idx] ? ST_OLD_COST : ST_NEW_COST;
                end
              end
              spq_pkg::MODE_POP: begin
                if (count == '0) begin
                  res_empty <= 1'b1;
                end else begin
                  count <= count_dec;
                  state <= ST_POP_NODE;
                end
              end
              default: ;
            endcase
          end
        end
        ST_OLD_COST: begin
          key     <= c_rdata;
          lo      <= '0;
          hi      <= count;
          for_old <= 1'b1;
          state   <= ST_SRCH;
        end
        ST_SRCH: begin
          if (lo == hi) begin
            pos <= lo;
            if (for_old) begin
              state <= ST_SCAN;
            end else begin
              idx   <= count;
              state <= ST_SHUP;
            end
          end else begin
            mid   <= mid_w;
            state <= ST_SRCH_NODE;
          end
        end
        ST_SRCH_NODE: state <= ST_SRCH_CMP;
        ST_SRCH_CMP: begin
          // descending queue: step past entries that cost more than the key
          if (cost_gt) begin
            lo <= mid + CW'(1);
          end else begin
            hi <= mid;
          end
          state <= ST_SRCH;
        end
        ST_SCAN: state <= (pos < count) ? ST_SCAN_CMP : ST_NEW_COST;
        ST_SCAN_CMP: begin
          if (q_rdata == node) begin
            count <= count_dec;
            idx   <= pos;
            state <= ST_SHDN;
          end else begin
            pos   <= pos + CW'(1);
            state <= ST_SCAN;
          end
        end
        ST_SHDN: state <= (idx < count) ? ST_SHDN_WR : ST_NEW_COST;
        ST_SHDN_WR: begin
          idx   <= idx_inc;
          state <= ST_SHDN;
        end
        ST_NEW_COST: begin
          node_open[node] <= 1'b1;
          if (count >= CW'(NODE_COUNT)) begin
            state <= ST_FIN;
          end else begin
            key     <= new_cost;
            lo      <= '0;
            hi      <= count;
            for_old <= 1'b0;
            state   <= ST_SRCH;
          end
        end
        ST_SHUP: state <= (idx > pos) ? ST_SHUP_WR : ST_INSERT;
        ST_SHUP_WR: begin
          idx   <= idx_dec;
          state <= ST_SHUP;
        end
        ST_INSERT: begin
          count <= count + CW'(1);
          state <= ST_FIN;
        end
        ST_POP_NODE: begin
          res_node           <= q_rdata;
          node_open[q_rdata] <= 1'b0;
          state              <= ST_POP_COST;
        end
        ST_POP_COST: begin
          res_cost <= c_rdata;
          state    <= ST_FIN;
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && (!m_tvalid || m_tready)) begin
      m_tdata <= {7'd0, spq_pkg::LEFT_W'(count), res_cost, spq_pkg::NODE_W'(res_node)};
      m_tuser <= res_empty;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/spq_checker.sv =====
// port-level checker for the sorted priority queue, bound to the top level
// depends on spq_pkg and sorted_priority_queue_decrease_key
`timescale 1ns / 1ps
`default_nettype none

module spq_checker #(
  parameter int NODE_COUNT = spq_pkg::NODE_COUNT_DEF
) (
  input wire                          clk,
  input wire                          rst,
  input wire                          s_tvalid,
  input wire                          s_tready,
  input wire [spq_pkg::S_USER_W-1:0]  s_tuser,
  input wire                          m_tvalid,
  input wire                          m_tready,
  input wire [spq_pkg::M_DATA_W-1:0]  m_tdata,
  input wire [spq_pkg::M_USER_W-1:0]  m_tuser
);

  // a held result does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one request at a time: busy right after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // an empty pop carries no node, no cost and no entries
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[48:0] == 49'd0))
    else $error("empty pop with payload");

  // entry count bounded by the node table and padding stays zero
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(m_tdata[48:40]) <= 32'(NODE_COUNT)) && (m_tdata[55:49] == 7'd0))
    else $error("entries_left out of range");

  // a clear answers with no node, no cost, no empty flag and no entries
  a_clear_out: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == spq_pkg::MODE_CLEAR) ##1 (!m_tvalid || m_tready)
      |=> m_tvalid && (m_tdata[48:0] == 49'd0) && (m_tuser[0] == 1'b0))
    else $error("clear returned a payload");

endmodule

bind sorted_priority_queue_decrease_key spq_checker #(
  .NODE_COUNT(NODE_COUNT)
) u_spq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/sorted_priority_queue_decrease_key_tb.sv =====
// self-checking bench for the sorted open-list priority queue: a cost/open-flag/order model
// predicts every response, randomized stream traffic with back-pressure drives the block
// depends on spq_pkg and the sorted_priority_queue_decrease_key top level
`timescale 1ns / 1ps

module sorted_priority_queue_decrease_key_tb;
  import spq_pkg::*;

  localparam int NODES = NODE_COUNT_DEF;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int TOTAL_REQUESTS = 1950;
  localparam int HOLD_OFF_AT = 150;
  localparam int HOLD_OFF_CYCLES = 600;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [COST_W-1:0] cost;
    logic              empty;
    logic [LEFT_W-1:0] left;
  } pop_result_t;

  // tracks node costs, open flags and the descending order list
  class open_list_model;
    logic [COST_W-1:0] cost_tab [NODES];
    bit                open_tab [NODES];
    logic [NODE_W-1:0] order [$];
    pop_result_t       expected_results [$];
    int                errors;

    function new();
      errors = 0;
      clear_all();
    endfunction

    function void clear_all();
      for (int i = 0; i < NODES; i++) begin
        cost_tab[i] = '1;
        open_tab[i] = 1'b0;
      end
      order.delete();
    endfunction

    // first slot whose cost is not above c
    function int first_not_above(logic [COST_W-1:0] c);
      int lo, hi, mid;
      lo = 0;
      hi = order.size();
      while (lo != hi) begin
        mid = (lo + hi) / 2;
        if (cost_tab[order[mid]] > c) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    function void note_request(logic [1:0] mode, logic [NODE_W-1:0] node,
                               logic [COST_W-1:0] c);
      pop_result_t r;
      int pos;
      r = '0;
      case (mode)
        MODE_CLEAR: clear_all();
        MODE_ADD: begin
          if (open_tab[node]) begin
            pos = first_not_above(cost_tab[node]);
            while (pos < order.size() && order[pos] != node) pos++;
            if (pos < order.size()) order.delete(pos);
          end
          cost_tab[node] = c;
          open_tab[node] = 1'b1;
          if (order.size() < NODES) order.insert(first_not_above(c), node);
        end
        MODE_POP: begin
          if (order.size() == 0) begin
            r.empty = 1'b1;
          end else begin
            r.node = order.pop_back();
            open_tab[r.node] = 1'b0;
            r.cost = cost_tab[r.node];
          end
        end
        default: ;
      endcase
      r.left = LEFT_W'(order.size());
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [M_DATA_W-1:0] data, logic [M_USER_W-1:0] user);
      pop_result_t e;
      if (expected_results.size() == 0) begin
        $error("response with no request outstanding: tdata %h tuser %h", data, user);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (data[NODE_W-1:0] !== e.node) begin
        $error("popped_node expected %0d actual %0d", e.node, data[NODE_W-1:0]);
        errors++;
      end
      if (data[NODE_W +: COST_W] !== e.cost) begin
        $error("popped_cost expected %h actual %h", e.cost, data[NODE_W +: COST_W]);
        errors++;
      end
      if (user[0] !== e.empty) begin
        $error("queue_empty expected %0d actual %0d", e.empty, user[0]);
        errors++;
      end
      if (data[NODE_W+COST_W +: LEFT_W] !== e.left) begin
        $error("entries_left expected %0d actual %0d", e.left, data[NODE_W+COST_W +: LEFT_W]);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;   // node_index, path_cost
  logic [S_USER_W-1:0] s_tuser;   // mode
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;   // popped_node, popped_cost, entries_left, pad
  logic [M_USER_W-1:0] m_tuser;   // queue_empty

  open_list_model model;
  int requests_sent;
  bit no_gaps;

  sorted_priority_queue_decrease_key #(
    .NODE_COUNT(NODES)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mix of full-range, clustered (many ties) and extreme costs
  function automatic logic [COST_W-1:0] pick_cost();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom();
    if (r < 65) return COST_W'($urandom_range(0, 7)) << $urandom_range(0, 29);
    if (r < 75) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
    return {16'($urandom_range(0, 15)), 16'h0000};
  endfunction

  task automatic send_request(logic [1:0] mode, logic [NODE_W-1:0] node,
                              logic [COST_W-1:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {c, node};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    model.note_request(mode, node, c);
    requests_sent++;
  endtask

  // response side back-pressure, with one long hold-off so the request side stalls
  initial begin
    int span, r;
    bit held;
    logic ready_next;
    held = 1'b0;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && requests_sent >= HOLD_OFF_AT) begin
        held = 1'b1;
        ready_next = 1'b0;
        span = HOLD_OFF_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          ready_next = 1'b1;
          span = $urandom_range(1, 40);
        end else if (r < 90) begin
          ready_next = 1'b0;
          span = $urandom_range(1, 3);
        end else if (r < 98) begin
          ready_next = 1'b0;
          span = $urandom_range(4, 15);
        end else begin
          ready_next = 1'b0;
          span = $urandom_range(30, 80);
        end
      end
      m_tready <= ready_next;
      repeat (span) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) model.check_result(m_tdata, m_tuser);
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [NODE_W-1:0] fill_order [NODES];
    logic [NODE_W-1:0] tmp;
    logic [NODE_W-1:0] node;
    logic [1:0] mode;
    int j, phase, phase_len, base, width, add_bias, r;
    model = new();
    requests_sent = 0;
    no_gaps = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= MODE_CLEAR;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_request(MODE_POP, 8'h00, 32'h0000_0000);        // empty right after reset
    send_request(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF);
    send_request(MODE_ADD, 8'h00, 32'h0000_0000);
    send_request(MODE_ADD, 8'hFF, 32'hFFFF_FFFF);
    send_request(MODE_ADD, 8'h55, 32'h0001_0000);
    send_request(MODE_ADD, 8'hAA, 32'h0001_0000);        // tie, pops after 0x55
    send_request(MODE_ADD, 8'h33, 32'h0001_0000);
    send_request(MODE_ADD, 8'hAA, 32'h0000_8000);        // decrease key
    send_request(MODE_ADD, 8'h55, 32'h0002_0000);        // increase key
    send_request(MODE_ADD, 8'h00, 32'h0000_0000);        // re-add at same cost
    send_request(MODE_UNUSED, 8'h12, 32'h1234_5678);
    for (int k = 0; k < 6; k++) send_request(MODE_POP, 8'hC3, 32'hDEAD_BEEF);
    send_request(MODE_ADD, 8'h80, 32'h7FFF_FFFF);
    send_request(MODE_ADD, 8'h01, 32'h8000_0000);
    send_request(MODE_CLEAR, 8'h7E, 32'h5A5A_A5A5);
    send_request(MODE_POP, 8'h00, 32'h0000_0000);        // empty after clear
    send_request(MODE_ADD, 8'h80, 32'h0000_0001);        // closed by the clear
    send_request(MODE_POP, 8'h00, 32'h0000_0000);

    phase = 0;
    while (requests_sent < TOTAL_REQUESTS) begin
      if (phase == 4) begin
        // fill every node once, reposition while full, then pop past empty
        for (int k = 0; k < NODES; k++) fill_order[k] = NODE_W'(k);
        for (int k = NODES - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = fill_order[k];
          fill_order[k] = fill_order[j];
          fill_order[j] = tmp;
        end
        no_gaps = ($urandom_range(0, 1) == 0);
        send_request(MODE_CLEAR, 8'h00, 32'h0000_0000);
        for (int k = 0; k < NODES; k++) send_request(MODE_ADD, fill_order[k], pick_cost());
        send_request(MODE_ADD, NODE_W'($urandom()), pick_cost());
        for (int k = 0; k <= NODES; k++) send_request(MODE_POP, NODE_W'($urandom()), $urandom());
      end else begin
        phase_len = $urandom_range(20, 120);
        base = $urandom_range(0, NODES - 1);
        width = $urandom_range(2, 40);
        add_bias = $urandom_range(40, 70);
        no_gaps = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 3) != 0) send_request(MODE_CLEAR, NODE_W'($urandom()), $urandom());
        for (int k = 0; k < phase_len; k++) begin
          r = $urandom_range(0, 99);
          if ($urandom_range(0, 9) == 0) node = NODE_W'($urandom());
          else node = NODE_W'(base + $urandom_range(0, width - 1));
          if (r < add_bias) mode = MODE_ADD;
          else if (r < 95) mode = MODE_POP;
          else if (r < 98) mode = MODE_UNUSED;
          else mode = MODE_CLEAR;
          send_request(mode, node, pick_cost());
        end
      end
      phase++;
    end
    s_tvalid <= 1'b0;

    while (model.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (model.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/spq_pkg.sv
rtl/core/sorted_priority_queue_decrease_key.sv
rtl/core/spq_checker.sv
tb/sorted_priority_queue_decrease_key_tb.sv
